@@ src/ptc_pkg.sv @@
// shared types, constants and helper functions for the compensation block
package ptc_pkg;

    localparam int RawW   = 20;
    localparam int TempW  = 16;
    localparam int PressW = 32;

    localparam logic [63:0] TFINE_OFFSET  = 64'd128000;
    localparam logic [20:0] PRESS_FULL    = 21'd1048576;
    localparam logic [63:0] DIV_SCALE     = 64'd3125;
    localparam logic [63:0] P1_BIAS       = 64'h0000_8000_0000_0000;
    localparam logic [31:0] ROUND_HALF    = 32'd128;

    // temperature result and raw pressure travelling from the front to the back
    typedef struct packed {
        logic [31:0]       tfine;
        logic [TempW-1:0]  tcent;
        logic [RawW-1:0]   raw_press;
    } ptc_item_t;

    // sign extend a 16-bit coefficient slice
    function automatic logic [63:0] sext16(input logic [15:0] v);
        sext16 = {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int s);
        asr64 = 64'($signed(x) >>> s);
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input int s);
        asr32 = 32'($signed(x) >>> s);
    endfunction

endpackage

@@ src/ptc_cfg.sv @@
// apb register file for the calibration coefficients
module ptc_cfg (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output logic [47:0] temp_coef,
    output logic [63:0] press_lo,
    output logic [63:0] press_hi,
    output logic [15:0] press_p9
);
    import ptc_pkg::*;

    localparam logic [1:0] REG_TEMP = 2'd0;
    localparam logic [1:0] REG_PLO  = 2'd1;
    localparam logic [1:0] REG_PHI  = 2'd2;
    localparam logic [1:0] REG_P9   = 2'd3;

    logic [47:0] temp_reg;
    logic [63:0] plo_reg;
    logic [63:0] phi_reg;
    logic [15:0] p9_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_reg <= '0;
            plo_reg  <= '0;
            phi_reg  <= '0;
            p9_reg   <= '0;
        end else if (wr_en) begin
            unique case (paddr[4:3])
                REG_TEMP: temp_reg <= pwdata[47:0];
                REG_PLO:  plo_reg  <= pwdata;
                REG_PHI:  phi_reg  <= pwdata;
                REG_P9:   p9_reg   <= pwdata[15:0];
                default:  ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (paddr[4:3])
            REG_TEMP: prdata = {16'b0, temp_reg};
            REG_PLO:  prdata = plo_reg;
            REG_PHI:  prdata = phi_reg;
            REG_P9:   prdata = {48'b0, p9_reg};
            default:  prdata = '0;
        endcase
    end

    assign temp_coef = temp_reg;
    assign press_lo  = plo_reg;
    assign press_hi  = phi_reg;
    assign press_p9  = p9_reg;
endmodule

@@ src/ptc_front.sv @@
// front: accepts raw pairs, computes fine temperature, queues items for the back
module ptc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [39:0]         s_tdata,
    input  logic [47:0]         temp_coef,
    output logic                q_valid,
    input  logic                q_pop,
    output ptc_pkg::ptc_item_t  q_item
);
    import ptc_pkg::*;

    logic [31:0] t1, t2s, t3s;
    logic        adv;

    // stage 1 registers
    logic        v1_reg;
    logic [31:0] pa_reg, bb_reg;
    logic [19:0] ap1_reg;
    // stage 2 registers
    logic        v2_reg;
    logic [31:0] var1_reg, m_reg;
    logic [19:0] ap2_reg;
    // stage 3 registers
    logic        v3_reg;
    ptc_item_t   it3_reg;

    logic [31:0] a_w, b_w, tfine_w, tc_w;
    logic [15:0] tsat_w;

    // queue
    ptc_item_t   mem_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        full, push;

    assign t1  = {16'b0, temp_coef[15:0]};
    assign t2s = 32'(sext16(temp_coef[31:16]));
    assign t3s = 32'(sext16(temp_coef[47:32]));

    assign full     = (cnt_reg == 2'd2);
    assign adv      = !(v3_reg && full);
    assign push     = v3_reg && !full;
    assign s_tready = adv;

    assign a_w = 32'(s_tdata[19:3]) - {t1[30:0], 1'b0};
    assign b_w = 32'(s_tdata[19:4]) - t1;

    // stage 3 math: fine temperature and saturated centidegrees
    always_comb begin
        tfine_w = var1_reg + asr32(m_reg, 14);
        tc_w    = asr32(tfine_w * 32'd5 + ROUND_HALF, 8);
        if ($signed(tc_w) > 32'sd32767)
            tsat_w = 16'h7fff;
        else if ($signed(tc_w) < -32'sd32768)
            tsat_w = 16'h8000;
        else
            tsat_w = tc_w[15:0];
    end

    // temperature pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pa_reg   <= a_w * t2s;
            bb_reg   <= b_w * b_w;
            ap1_reg  <= s_tdata[39:20];
            var1_reg <= asr32(pa_reg, 11);
            m_reg    <= asr32(bb_reg, 12) * t3s;
            ap2_reg  <= ap1_reg;
            it3_reg.tfine     <= tfine_w;
            it3_reg.tcent     <= tsat_w;
            it3_reg.raw_press <= ap2_reg;
        end
    end

    // two-entry queue toward the back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (q_pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= it3_reg;
    end

    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rp_reg];
endmodule

@@ src/ptc_mul.sv @@
// 64x64 low-half multiplier built from one 32x32 unit, accumulating the partial products in turn
module ptc_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        run,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] result
);
    import ptc_pkg::*;

    logic [1:0]  step_reg;
    logic [63:0] acc_reg;
    logic [31:0] ma, mb;
    logic [63:0] prod;

    // partial product select
    always_comb begin
        case (step_reg)
            2'd0:    begin ma = a[31:0];  mb = b[31:0];  end
            2'd1:    begin ma = a[31:0];  mb = b[63:32]; end
            default: begin ma = a[63:32]; mb = b[31:0];  end
        endcase
    end

    assign prod   = {32'b0, ma} * {32'b0, mb};
    assign done   = run && (step_reg == 2'd2);
    assign result = acc_reg + {prod[31:0], 32'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= 2'd0;
        end else if (run) begin
            step_reg <= (step_reg == 2'd2) ? 2'd0 : step_reg + 2'd1;
        end else begin
            step_reg <= 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_reg == 2'd0)
            acc_reg <= prod;
        else
            acc_reg <= result;
    end
endmodule

@@ src/ptc_div.sv @@
// signed 64-bit divider, truncating, one quotient bit per cycle
module ptc_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quot
);
    import ptc_pkg::*;

    logic        busy_reg, fin_reg, neg_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] rem_reg, quo_reg, dm_reg;
    logic [64:0] rsh, rdif;

    assign rsh  = {rem_reg, quo_reg[63]};
    assign rdif = rsh - {1'b0, dm_reg};
    assign done = fin_reg;
    assign quot = neg_reg ? (~quo_reg + 64'd1) : quo_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            fin_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    // restoring shift-subtract on magnitudes
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[63] ^ den[63];
            quo_reg <= num[63] ? (~num + 64'd1) : num;
            dm_reg  <= den[63] ? (~den + 64'd1) : den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (!rdif[64]) begin
                rem_reg <= rdif[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end else begin
                rem_reg <= rsh[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end
endmodule

@@ src/ptc_back.sv @@
// back: pressure sequencer over a shared multiplier and divider, output register
module ptc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_pop,
    input  ptc_pkg::ptc_item_t  q_item,
    input  logic [63:0]         press_lo,
    input  logic [63:0]         press_hi,
    input  logic [15:0]         press_p9,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         out_temp,
    output logic [31:0]         out_press,
    output logic                out_inv
);
    import ptc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;

    localparam logic [3:0] OP_SQ    = 4'd0;
    localparam logic [3:0] OP_SQP6  = 4'd1;
    localparam logic [3:0] OP_P5    = 4'd2;
    localparam logic [3:0] OP_SQP3  = 4'd3;
    localparam logic [3:0] OP_P2    = 4'd4;
    localparam logic [3:0] OP_P1    = 4'd5;
    localparam logic [3:0] OP_SCALE = 4'd6;
    localparam logic [3:0] OP_P9Q   = 4'd7;
    localparam logic [3:0] OP_TQ    = 4'd8;
    localparam logic [3:0] OP_P8    = 4'd9;

    logic [2:0]  state_reg;
    logic [3:0]  op_reg;
    logic [63:0] w1_reg, w2_reg, sq_reg, acc_reg, p_reg, q_reg, t_reg;
    logic [15:0] tc_reg;
    logic [19:0] ap_reg;
    logic        inv_reg, dstart_reg;

    logic        ovalid_reg;
    logic [15:0] otemp_reg;
    logic [31:0] opress_reg;
    logic        oinv_reg;

    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] ma, mb, mres, nbase, qdiv, pf, w1new;
    logic        mdone, ddone, orun;
    logic [31:0] psat;
    logic [20:0] pdiff;

    assign p1 = {48'b0, press_lo[15:0]};
    assign p2 = sext16(press_lo[31:16]);
    assign p3 = sext16(press_lo[47:32]);
    assign p4 = sext16(press_lo[63:48]);
    assign p5 = sext16(press_hi[15:0]);
    assign p6 = sext16(press_hi[31:16]);
    assign p7 = sext16(press_hi[47:32]);
    assign p8 = sext16(press_hi[63:48]);
    assign p9 = sext16(press_p9);

    assign pdiff = PRESS_FULL - {1'b0, ap_reg};
    assign nbase = ({43'b0, pdiff} << 31) - w2_reg;
    assign w1new = asr64(mres, 33);

    // multiplier operands per step
    always_comb begin
        unique case (op_reg)
            OP_SQ:    begin ma = w1_reg;             mb = w1_reg;    end
            OP_SQP6:  begin ma = sq_reg;             mb = p6;        end
            OP_P5:    begin ma = w1_reg;             mb = p5;        end
            OP_SQP3:  begin ma = sq_reg;             mb = p3;        end
            OP_P2:    begin ma = w1_reg;             mb = p2;        end
            OP_P1:    begin ma = P1_BIAS + acc_reg;  mb = p1;        end
            OP_SCALE: begin ma = nbase;              mb = DIV_SCALE; end
            OP_P9Q:   begin ma = p9;                 mb = q_reg;     end
            OP_TQ:    begin ma = t_reg;              mb = q_reg;     end
            OP_P8:    begin ma = p8;                 mb = p_reg;     end
            default:  begin ma = '0;                 mb = '0;        end
        endcase
    end

    ptc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .run     (state_reg == ST_MUL),
        .a       (ma),
        .b       (mb),
        .done    (mdone),
        .result  (mres)
    );

    ptc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dstart_reg),
        .num     (t_reg),
        .den     (w1_reg),
        .done    (ddone),
        .quot    (qdiv)
    );

    // final combine and saturation
    always_comb begin
        pf = asr64(p_reg + w1_reg + w2_reg, 8) + (p7 << 4);
        if (pf[63])
            psat = '0;
        else if (|pf[62:32])
            psat = '1;
        else
            psat = pf[31:0];
    end

    assign orun  = !ovalid_reg || out_ready;
    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            op_reg     <= OP_SQ;
            dstart_reg <= 1'b0;
        end else begin
            dstart_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        state_reg <= ST_MUL;
                        op_reg    <= OP_SQ;
                    end
                end
                ST_MUL: begin
                    if (mdone) begin
                        op_reg <= op_reg + 4'd1;
                        if (op_reg == OP_P1 && w1new == '0)
                            state_reg <= ST_FIN;
                        else if (op_reg == OP_SCALE) begin
                            state_reg  <= ST_DIV;
                            dstart_reg <= 1'b1;
                        end else if (op_reg == OP_P8)
                            state_reg <= ST_FIN;
                    end
                end
                ST_DIV: begin
                    if (ddone) state_reg <= ST_MUL;
                end
                ST_FIN: begin
                    if (orun) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            w1_reg  <= {{32{q_item.tfine[31]}}, q_item.tfine} - TFINE_OFFSET;
            tc_reg  <= q_item.tcent;
            ap_reg  <= q_item.raw_press;
            inv_reg <= 1'b0;
        end
        if (state_reg == ST_MUL && mdone) begin
            case (op_reg)
                OP_SQ:    sq_reg  <= mres;
                OP_SQP6:  w2_reg  <= mres;
                OP_P5:    w2_reg  <= w2_reg + (mres << 17) + (p4 << 35);
                OP_SQP3:  acc_reg <= asr64(mres, 8);
                OP_P2:    acc_reg <= acc_reg + (mres << 12);
                OP_P1: begin
                    w1_reg  <= w1new;
                    inv_reg <= (w1new == '0);
                end
                OP_SCALE: t_reg   <= mres;
                OP_P9Q:   t_reg   <= mres;
                OP_TQ:    w1_reg  <= asr64(mres, 25);
                OP_P8:    w2_reg  <= asr64(mres, 19);
                default:  ;
            endcase
        end
        if (state_reg == ST_DIV && ddone) begin
            p_reg <= qdiv;
            q_reg <= asr64(qdiv, 13);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (state_reg == ST_FIN && orun) begin
            ovalid_reg <= 1'b1;
        end else if (out_ready) begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && orun) begin
            otemp_reg  <= tc_reg;
            opress_reg <= inv_reg ? '0 : psat;
            oinv_reg   <= inv_reg;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_temp  = otemp_reg;
    assign out_press = opress_reg;
    assign out_inv   = oinv_reg;
endmodule

@@ src/pressure_temperature_compensation.sv @@
// Top level of the pressure and temperature compensation block.
// The back end handles one item at a time: it takes no new item from the queue until the
// current one has been loaded into the output register. It is paced by the shared
// multiplier (ten products) and the 64-step radix-2 divider, used in turn.
// The front temperature pipeline and two-entry queue accept items meanwhile, until the queue is full.
// Reset: synchronous active-low aresetn clears control state and coefficients to 0.
module pressure_temperature_compensation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // raw_temperature [19:0], raw_pressure [39:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // temperature_centi [15:0], pressure_q24_8 [47:16]
    output logic [0:0]  m_tuser,    // pressure_invalid [0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import ptc_pkg::*;

    logic [47:0] temp_coef;
    logic [63:0] press_lo, press_hi;
    logic [15:0] press_p9;
    logic        q_valid, q_pop;
    ptc_item_t   q_item;
    logic [15:0] out_temp;
    logic [31:0] out_press;
    logic        out_inv;

    ptc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .temp_coef (temp_coef),
        .press_lo  (press_lo),
        .press_hi  (press_hi),
        .press_p9  (press_p9)
    );

    ptc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .temp_coef (temp_coef),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item)
    );

    ptc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .press_lo  (press_lo),
        .press_hi  (press_hi),
        .press_p9  (press_p9),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_temp  (out_temp),
        .out_press (out_press),
        .out_inv   (out_inv)
    );

    assign m_tdata = {out_press, out_temp};
    assign m_tuser = out_inv;
endmodule
